[rtl/mcau_pkg.sv]
// ----------------------------------------------------------------------------
// MSHR conflict admission package
// Shared codes, phase encodings and the word formats passed between the
// front queue, the engine and the result queue.
// ----------------------------------------------------------------------------
package mcau_pkg;

   // Default sizes of the entry tables and queues.
   localparam int DOWN_ENTRIES_DEF = 16;
   localparam int UP_ENTRIES_DEF   = 8;
   localparam int PEND_DEPTH_DEF   = 16;
   localparam int LINE_BITS_DEF    = 32;

   // Configuration register file.
   localparam int          CSR_ADDR_BITS  = 3;
   localparam logic [31:0] SET_MASK_RESET = 32'd1023;
   localparam logic [4:0]  WAYS_RESET     = 5'd8;

   typedef enum logic {
      CSR_REG_SET_MASK = 1'b0,
      CSR_REG_WAYS     = 1'b1
   } csr_reg_type;

   typedef enum logic [2:0] {
      OP_INSERT_DOWN = 3'd0,
      OP_INSERT_UP   = 3'd1,
      OP_ISSUE_DOWN  = 3'd2,
      OP_ISSUE_UP    = 3'd3,
      OP_UP_TO_WAIT  = 3'd4,
      OP_UP_TO_ACK   = 3'd5,
      OP_RETIRE_DOWN = 3'd6,
      OP_RETIRE_UP   = 3'd7
   } op_type;

   typedef enum logic [3:0] {
      RK_INSERT_GRANTED   = 4'd0,
      RK_INSERT_DEFERRED  = 4'd1,
      RK_INSERT_DROPPED   = 4'd2,
      RK_ISSUE_GRANTED    = 4'd3,
      RK_ISSUE_BLOCKED    = 4'd4,
      RK_RETRY_ISSUE_DOWN = 4'd5,
      RK_RETRY_ISSUE_UP   = 4'd6,
      RK_RETRY_INS_DOWN   = 4'd7,
      RK_RETRY_INS_UP     = 4'd8,
      RK_UPDATED          = 4'd9,
      RK_NO_MATCH         = 4'd10
   } kind_type;

   typedef enum logic [1:0] {
      DP_FREE     = 2'd0,
      DP_INACTIVE = 2'd1,
      DP_ACTIVE   = 2'd2
   } down_phase_type;

   typedef enum logic [2:0] {
      UP_FREE  = 3'd0,
      UP_SLEEP = 3'd1,
      UP_REQ   = 3'd2,
      UP_WAIT  = 3'd3,
      UP_ACK   = 3'd4
   } up_phase_type;

   typedef enum logic [1:0] {
      BK_NONE  = 2'd0,
      BK_DOWN  = 2'd1,
      BK_UP    = 2'd2,
      BK_COUNT = 2'd3
   } blk_kind_type;

   typedef enum logic [1:0] {
      ES_IDLE,
      ES_DECIDE,
      ES_WAKE,
      ES_DRAIN
   } eng_state_type;

   // Classified request word from the front queue (line travels separately).
   typedef struct packed {
      op_type     op;
      logic [3:0] entry_id;
      logic [7:0] tag;
   } job_type;

   // One result word.
   typedef struct packed {
      kind_type    kind;
      logic [3:0]  entry;
      logic [31:0] line;
      logic [7:0]  tag;
      logic        last;
   } rsp_type;

endpackage

[rtl/mshr_conflict_admission_unit.sv]
// ----------------------------------------------------------------------------
// MSHR conflict admission unit
// Miss-status table with downgrade and upgrade entries, conflict-checked
// issue, wake lists and bounded pending-insert queues.
//
//   channel   ports                               handshake
//   request   req_action/line_addr/entry_id/tag   push / full
//   result    rsp_result_kind/out_entry/...       empty / pop
//   config    paddr, pwdata, prdata               psel, penable, pwrite
//
// A request is first matched against every entry, with the match
// registered, and then decided, with its first result word written. Each
// further word (a retried waiter or a drained pending insert) follows in turn.
// The front and result queues hold two words each; a full result queue
// stalls the engine, a busy engine fills the front queue. Synchronous reset
// frees every entry and empties both pending queues at once.
// ----------------------------------------------------------------------------
module mshr_conflict_admission_unit
   import mcau_pkg::*;
#(
   parameter int DOWN_ENTRIES      = DOWN_ENTRIES_DEF,
   parameter int UP_ENTRIES        = UP_ENTRIES_DEF,
   parameter int PEND_INSERT_DEPTH = PEND_DEPTH_DEF,
   parameter int LINE_ADDR_BITS    = LINE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  logic [2:0]               req_action,
   input  logic [31:0]              req_line_addr,
   input  logic [3:0]               req_entry_id,
   input  logic [7:0]               req_tag,
   output logic                     empty,
   input  logic                     pop,
   output logic [3:0]               rsp_result_kind,
   output logic [3:0]               rsp_out_entry,
   output logic [31:0]              rsp_out_line,
   output logic [7:0]               rsp_out_tag,
   output logic                     rsp_last,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   logic [31:0]               set_mask_ff;
   logic [4:0]                ways_ff;
   logic                      csr_wr;
   csr_reg_type               csr_reg;
   logic                      job_valid, job_pop;
   job_type                   job;
   logic [LINE_ADDR_BITS-1:0] job_line;
   logic                      res_valid, res_ready;
   rsp_type                   res, head;

   // Configuration registers.
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_reg = csr_reg_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         set_mask_ff <= SET_MASK_RESET;
         ways_ff     <= WAYS_RESET;
      end else if (csr_wr) begin
         case (csr_reg)
            CSR_REG_SET_MASK: set_mask_ff <= pwdata;
            CSR_REG_WAYS:     ways_ff     <= pwdata[4:0];
            default:          ways_ff     <= ways_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         CSR_REG_SET_MASK: prdata = set_mask_ff;
         CSR_REG_WAYS:     prdata = {27'd0, ways_ff};
         default:          prdata = 32'd0;
      endcase
   end

   mcau_front #(
      .LINE_ADDR_BITS(LINE_ADDR_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .in_action  (req_action),
      .in_line    (req_line_addr),
      .in_entry_id(req_entry_id),
      .in_tag     (req_tag),
      .job_valid  (job_valid),
      .job        (job),
      .job_line   (job_line),
      .job_pop    (job_pop)
   );

   mcau_engine #(
      .DOWN_ENTRIES     (DOWN_ENTRIES),
      .UP_ENTRIES       (UP_ENTRIES),
      .PEND_INSERT_DEPTH(PEND_INSERT_DEPTH),
      .LINE_ADDR_BITS   (LINE_ADDR_BITS)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .set_mask (set_mask_ff),
      .ways     (ways_ff),
      .job_valid(job_valid),
      .job      (job),
      .job_line (job_line),
      .job_pop  (job_pop),
      .res_valid(res_valid),
      .res      (res),
      .res_ready(res_ready)
   );

   mcau_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .res_valid(res_valid),
      .res      (res),
      .res_ready(res_ready),
      .empty    (empty),
      .pop      (pop),
      .head     (head)
   );

   // Result ports.
   assign rsp_result_kind = head.kind;
   assign rsp_out_entry   = head.entry;
   assign rsp_out_line    = head.line;
   assign rsp_out_tag     = head.tag;
   assign rsp_last        = head.last;

endmodule

[rtl/mcau_front.sv]
// ----------------------------------------------------------------------------
// MSHR front queue
// Accepts request words, classifies the action code and trims the line
// address, and holds up to two words for the engine.
// ----------------------------------------------------------------------------
module mcau_front
   import mcau_pkg::*;
#(
   parameter int LINE_ADDR_BITS = LINE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic [2:0]                in_action,
   input  logic [31:0]               in_line,
   input  logic [3:0]                in_entry_id,
   input  logic [7:0]                in_tag,
   output logic                      job_valid,
   output job_type                   job,
   output logic [LINE_ADDR_BITS-1:0] job_line,
   input  logic                      job_pop
);

   job_type                   job_q_ff [2];
   logic [LINE_ADDR_BITS-1:0] line_q_ff [2];
   logic                      wr_ptr_ff, wr_ptr_in;
   logic                      rd_ptr_ff, rd_ptr_in;
   logic [1:0]                count_ff, count_in;
   logic                      accept;
   logic                      take;
   job_type                   new_job;

   // Classify the incoming word.
   always_comb begin
      new_job.op       = op_type'(in_action);
      new_job.entry_id = in_entry_id;
      new_job.tag      = in_tag;
   end

   assign full      = (count_ff == 2'd2);
   assign job_valid = (count_ff != 2'd0);
   assign accept    = push && !full;
   assign take      = job_pop && job_valid;
   assign job       = job_q_ff[rd_ptr_ff];
   assign job_line  = line_q_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = accept ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, accept} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Word storage.
   always_ff @(posedge clock) begin
      if (accept) begin
         job_q_ff[wr_ptr_ff]  <= new_job;
         line_q_ff[wr_ptr_ff] <= LINE_ADDR_BITS'(in_line);
      end
   end

endmodule

[rtl/mcau_rsp_queue.sv]
// ----------------------------------------------------------------------------
// MSHR result queue
// Two-word queue between the engine and the result ports, so the engine
// keeps working while a finished result waits to be popped.
// ----------------------------------------------------------------------------
module mcau_rsp_queue
   import mcau_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    res_valid,
   input  rsp_type res,
   output logic    res_ready,
   output logic    empty,
   input  logic    pop,
   output rsp_type head
);

   rsp_type    mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       put, take;

   assign res_ready = (count_ff != 2'd2);
   assign empty     = (count_ff == 2'd0);
   assign put       = res_valid && res_ready;
   assign take      = pop && !empty;
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff + {1'b0, put} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (put) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (take) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (put) begin
         mem_ff[wr_ptr_ff] <= res;
      end
   end

endmodule

[rtl/mcau_engine.sv]
// ----------------------------------------------------------------------------
// MSHR engine
// Holds the downgrade and upgrade tables and the pending-insert queues.
// Matches a request against all entries, decides and reports in the next cycle,
// then walks wake vectors and the pending queue one word a cycle unless stalled.
// ----------------------------------------------------------------------------
module mcau_engine
   import mcau_pkg::*;
#(
   parameter int DOWN_ENTRIES      = DOWN_ENTRIES_DEF,
   parameter int UP_ENTRIES        = UP_ENTRIES_DEF,
   parameter int PEND_INSERT_DEPTH = PEND_DEPTH_DEF,
   parameter int LINE_ADDR_BITS    = LINE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [31:0]               set_mask,
   input  logic [4:0]                ways,
   input  logic                      job_valid,
   input  job_type                   job,
   input  logic [LINE_ADDR_BITS-1:0] job_line,
   output logic                      job_pop,
   output logic                      res_valid,
   output rsp_type                   res,
   input  logic                      res_ready
);

   localparam int LW  = LINE_ADDR_BITS;
   localparam int DIW = (DOWN_ENTRIES > 1) ? $clog2(DOWN_ENTRIES) : 1;
   localparam int UIW = (UP_ENTRIES > 1) ? $clog2(UP_ENTRIES) : 1;
   localparam int BIW = (DIW > UIW) ? DIW : UIW;
   localparam int PIW = (PEND_INSERT_DEPTH > 1) ? $clog2(PEND_INSERT_DEPTH) : 1;
   localparam int PCW = $clog2(PEND_INSERT_DEPTH + 1);
   localparam int DCW = $clog2(DOWN_ENTRIES + 1);

   // Entry tables.
   down_phase_type  down_phase_ff [DOWN_ENTRIES];
   logic [LW-1:0]   down_line_ff [DOWN_ENTRIES];
   logic [7:0]      down_tag_ff [DOWN_ENTRIES];
   blk_kind_type    down_bk_kind_ff [DOWN_ENTRIES];
   logic [BIW-1:0]  down_bk_idx_ff [DOWN_ENTRIES];
   up_phase_type    up_phase_ff [UP_ENTRIES];
   logic [LW-1:0]   up_line_ff [UP_ENTRIES];
   logic [7:0]      up_tag_ff [UP_ENTRIES];
   blk_kind_type    up_bk_kind_ff [UP_ENTRIES];
   logic [BIW-1:0]  up_bk_idx_ff [UP_ENTRIES];

   // Pending-insert queues.
   logic [LW-1:0]   pdn_line_ff [PEND_INSERT_DEPTH];
   logic [7:0]      pdn_tag_ff [PEND_INSERT_DEPTH];
   logic [PCW-1:0]  pdn_cnt_ff;
   logic [LW-1:0]   pup_line_ff [PEND_INSERT_DEPTH];
   logic [7:0]      pup_tag_ff [PEND_INSERT_DEPTH];
   logic [PCW-1:0]  pup_cnt_ff;

   // Match stage registers.
   op_type                 op_ff;
   logic [3:0]             id_ff;
   logic [LW-1:0]          tline_ff;
   logic [7:0]             ttag_ff;
   logic                   id_ok_ff;
   logic [DOWN_ENTRIES-1:0] dline_hit_ff, dset_act_ff;
   logic [UP_ENTRIES-1:0]   uline_eq_ff, uset_eq_ff;

   // Wake and drain walk.
   logic [DOWN_ENTRIES-1:0] wake_d_ff;
   logic [UP_ENTRIES-1:0]   wake_u_ff;
   logic                    drain_pend_ff;
   logic                    drain_up_ff;
   logic [PCW-1:0]          drain_idx_ff;

   eng_state_type state_ff, state_in;

   // ----- match stage signals -----
   logic [DIW-1:0]          id_d;
   logic [UIW-1:0]          id_u;
   logic [LW-1:0]           m_line;
   logic [7:0]              m_tag;
   logic                    m_ok;
   logic [31:0]             m_set;
   logic [DOWN_ENTRIES-1:0] m_dline_hit, m_dset_act;
   logic [UP_ENTRIES-1:0]   m_uline_eq, m_uset_eq;

   // ----- decide stage signals -----
   logic                    x_found, us_found, um_found, df_found, uf_found;
   logic [DIW-1:0]          x_idx, df_idx;
   logic [UIW-1:0]          us_idx, um_idx, uf_idx;
   logic [UP_ENTRIES-1:0]   up_issued, up_cond;
   logic [DCW-1:0]          dcount;
   kind_type                d_kind;
   logic [3:0]              d_entry;
   logic [31:0]             d_line;
   logic [7:0]              d_tag;
   blk_kind_type            d_bk_kind;
   logic [BIW-1:0]          d_bk_idx;
   logic                    wk_en, wk_ups, wk_count;
   blk_kind_type            wk_kind;
   logic [BIW-1:0]          wk_idx;
   logic [DOWN_ENTRIES-1:0] wd;
   logic [UP_ENTRIES-1:0]   wu;
   logic                    drain_go, drain_sel_up;
   logic [PCW-1:0]          drain_cnt_now;
   logic                    d_last;

   // ----- walk signals -----
   logic                    wd_any, wu_any;
   logic [DIW-1:0]          wd_idx;
   logic [UIW-1:0]          wu_idx;
   logic [DOWN_ENTRIES-1:0] wd_rest;
   logic [UP_ENTRIES-1:0]   wu_rest;
   logic                    walk_more;
   logic [PCW-1:0]          drain_cnt;
   logic                    drain_last;

   logic                    commit;

   // Select the line a request works on and compare it with every entry.
   always_comb begin
      id_d   = DIW'(job.entry_id);
      id_u   = UIW'(job.entry_id);
      m_line = job_line;
      m_tag  = job.tag;
      m_ok   = 1'b1;
      case (job.op)
         OP_ISSUE_DOWN: begin
            m_line = down_line_ff[id_d];
            m_tag  = down_tag_ff[id_d];
            m_ok   = (32'(job.entry_id) < 32'(DOWN_ENTRIES)) &&
                     (down_phase_ff[id_d] == DP_INACTIVE);
         end
         OP_ISSUE_UP: begin
            m_line = up_line_ff[id_u];
            m_tag  = up_tag_ff[id_u];
            m_ok   = (32'(job.entry_id) < 32'(UP_ENTRIES)) &&
                     (up_phase_ff[id_u] == UP_SLEEP);
         end
         default: begin
            m_ok = 1'b1;
         end
      endcase
      m_set = 32'(m_line) & set_mask;
      for (int d = 0; d < DOWN_ENTRIES; d++) begin
         m_dline_hit[d] = (down_phase_ff[d] == DP_ACTIVE) && (down_line_ff[d] == m_line);
         m_dset_act[d]  = (down_phase_ff[d] == DP_ACTIVE) &&
                          ((32'(down_line_ff[d]) & set_mask) == m_set);
      end
      for (int u = 0; u < UP_ENTRIES; u++) begin
         m_uline_eq[u] = (up_line_ff[u] == m_line);
         m_uset_eq[u]  = ((32'(up_line_ff[u]) & set_mask) == m_set);
      end
   end

   // Lowest-index searches over the registered match vectors.
   always_comb begin
      for (int u = 0; u < UP_ENTRIES; u++) begin
         up_issued[u] = (up_phase_ff[u] == UP_REQ) || (up_phase_ff[u] == UP_WAIT) ||
                        (up_phase_ff[u] == UP_ACK);
         case (op_ff)
            OP_UP_TO_WAIT: up_cond[u] = (up_phase_ff[u] == UP_REQ);
            OP_UP_TO_ACK:  up_cond[u] = (up_phase_ff[u] == UP_REQ) ||
                                        (up_phase_ff[u] == UP_WAIT);
            OP_RETIRE_UP:  up_cond[u] = (up_phase_ff[u] == UP_ACK);
            default:       up_cond[u] = 1'b0;
         endcase
      end
      x_found  = 1'b0;
      x_idx    = '0;
      df_found = 1'b0;
      df_idx   = '0;
      for (int d = DOWN_ENTRIES - 1; d >= 0; d--) begin
         if (dline_hit_ff[d]) begin
            x_found = 1'b1;
            x_idx   = DIW'(d);
         end
         if (down_phase_ff[d] == DP_FREE) begin
            df_found = 1'b1;
            df_idx   = DIW'(d);
         end
      end
      us_found = 1'b0;
      us_idx   = '0;
      um_found = 1'b0;
      um_idx   = '0;
      uf_found = 1'b0;
      uf_idx   = '0;
      for (int u = UP_ENTRIES - 1; u >= 0; u--) begin
         if (uset_eq_ff[u] && up_issued[u]) begin
            us_found = 1'b1;
            us_idx   = UIW'(u);
         end
         if (uline_eq_ff[u] && up_cond[u]) begin
            um_found = 1'b1;
            um_idx   = UIW'(u);
         end
         if (up_phase_ff[u] == UP_FREE) begin
            uf_found = 1'b1;
            uf_idx   = UIW'(u);
         end
      end
      dcount = DCW'($countones(dset_act_ff));
   end

   // Decision for the first result of a request.
   always_comb begin
      d_kind    = RK_NO_MATCH;
      d_entry   = 4'd0;
      d_line    = 32'(tline_ff);
      d_tag     = ttag_ff;
      d_bk_kind = BK_NONE;
      d_bk_idx  = '0;
      wk_en     = 1'b0;
      wk_ups    = 1'b0;
      wk_count  = 1'b0;
      wk_kind   = BK_NONE;
      wk_idx    = '0;
      drain_go  = 1'b0;
      drain_sel_up = 1'b0;
      case (op_ff)
         OP_INSERT_DOWN: begin
            if (df_found) begin
               d_kind  = RK_INSERT_GRANTED;
               d_entry = 4'(df_idx);
            end else if (pdn_cnt_ff < PCW'(PEND_INSERT_DEPTH)) begin
               d_kind = RK_INSERT_DEFERRED;
            end else begin
               d_kind = RK_INSERT_DROPPED;
            end
         end
         OP_INSERT_UP: begin
            if (uf_found) begin
               d_kind  = RK_INSERT_GRANTED;
               d_entry = 4'(uf_idx);
            end else if (pup_cnt_ff < PCW'(PEND_INSERT_DEPTH)) begin
               d_kind = RK_INSERT_DEFERRED;
            end else begin
               d_kind = RK_INSERT_DROPPED;
            end
         end
         OP_ISSUE_DOWN, OP_ISSUE_UP: begin
            d_entry = id_ff;
            if (!id_ok_ff) begin
               d_kind = RK_NO_MATCH;
               d_line = 32'd0;
               d_tag  = 8'd0;
            end else begin
               d_kind = RK_ISSUE_BLOCKED;
               if (op_ff == OP_ISSUE_DOWN) begin
                  if (x_found) begin
                     d_bk_kind = BK_DOWN;
                     d_bk_idx  = BIW'(x_idx);
                  end else if (us_found && ((up_phase_ff[us_idx] == UP_REQ) ||
                               ((up_phase_ff[us_idx] == UP_ACK) && uline_eq_ff[us_idx]))) begin
                     d_bk_kind = BK_UP;
                     d_bk_idx  = BIW'(us_idx);
                  end else begin
                     d_kind = RK_ISSUE_GRANTED;
                  end
               end else begin
                  if (us_found) begin
                     d_bk_kind = BK_UP;
                     d_bk_idx  = BIW'(us_idx);
                  end else if (x_found) begin
                     d_bk_kind = BK_DOWN;
                     d_bk_idx  = BIW'(x_idx);
                  end else if (32'(dcount) >= 32'(ways)) begin
                     d_bk_kind = BK_COUNT;
                  end else begin
                     d_kind = RK_ISSUE_GRANTED;
                  end
               end
            end
         end
         OP_RETIRE_DOWN: begin
            if (x_found) begin
               d_kind   = RK_UPDATED;
               d_entry  = 4'(x_idx);
               d_tag    = down_tag_ff[x_idx];
               wk_en    = 1'b1;
               wk_ups   = 1'b1;
               wk_count = 1'b1;
               wk_kind  = BK_DOWN;
               wk_idx   = BIW'(x_idx);
               drain_go = 1'b1;
            end else begin
               d_tag = 8'd0;
            end
         end
         default: begin
            // Upgrade phase steps: up-to-wait, up-to-ack and retire of an upgrade.
            if (um_found) begin
               d_kind  = RK_UPDATED;
               d_entry = 4'(um_idx);
               d_tag   = up_tag_ff[um_idx];
               wk_kind = BK_UP;
               wk_idx  = BIW'(um_idx);
               if (op_ff == OP_UP_TO_WAIT) begin
                  wk_en = 1'b1;
               end else if (op_ff == OP_RETIRE_UP) begin
                  wk_en        = 1'b1;
                  wk_ups       = 1'b1;
                  drain_go     = 1'b1;
                  drain_sel_up = 1'b1;
               end
            end else begin
               d_tag = 8'd0;
            end
         end
      endcase

      // Waiters released by this step.
      for (int d = 0; d < DOWN_ENTRIES; d++) begin
         wd[d] = wk_en && (down_phase_ff[d] == DP_INACTIVE) &&
                 (down_bk_kind_ff[d] == wk_kind) && (down_bk_idx_ff[d] == wk_idx);
      end
      for (int u = 0; u < UP_ENTRIES; u++) begin
         wu[u] = wk_en && wk_ups && (up_phase_ff[u] == UP_SLEEP) &&
                 (((up_bk_kind_ff[u] == wk_kind) && (up_bk_idx_ff[u] == wk_idx)) ||
                  (wk_count && (up_bk_kind_ff[u] == BK_COUNT) &&
                   (up_bk_idx_ff[u] == '0) && uset_eq_ff[u]));
      end
      drain_cnt_now = drain_sel_up ? pup_cnt_ff : pdn_cnt_ff;
      d_last = !(|wd) && !(|wu) && !(drain_go && (drain_cnt_now != '0));
   end

   // Walk over released waiters and pending inserts.
   always_comb begin
      wd_any = |wake_d_ff;
      wu_any = |wake_u_ff;
      wd_idx = '0;
      wu_idx = '0;
      for (int d = DOWN_ENTRIES - 1; d >= 0; d--) begin
         if (wake_d_ff[d]) begin
            wd_idx = DIW'(d);
         end
      end
      for (int u = UP_ENTRIES - 1; u >= 0; u--) begin
         if (wake_u_ff[u]) begin
            wu_idx = UIW'(u);
         end
      end
      wd_rest = wake_d_ff;
      wu_rest = wake_u_ff;
      if (wd_any) begin
         wd_rest[wd_idx] = 1'b0;
      end else begin
         wu_rest[wu_idx] = 1'b0;
      end
      walk_more  = (|wd_rest) || (|wu_rest);
      drain_cnt  = drain_up_ff ? pup_cnt_ff : pdn_cnt_ff;
      drain_last = ((drain_idx_ff + PCW'(1)) == drain_cnt);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ES_IDLE: begin
            if (job_valid) begin
               state_in = ES_DECIDE;
            end
         end
         ES_DECIDE: begin
            if (res_ready) begin
               if ((|wd) || (|wu)) begin
                  state_in = ES_WAKE;
               end else if (!d_last) begin
                  state_in = ES_DRAIN;
               end else begin
                  state_in = ES_IDLE;
               end
            end
         end
         ES_WAKE: begin
            if (res_ready && !walk_more) begin
               state_in = drain_pend_ff ? ES_DRAIN : ES_IDLE;
            end
         end
         ES_DRAIN: begin
            if (res_ready && drain_last) begin
               state_in = ES_IDLE;
            end
         end
         default: begin
            state_in = ES_IDLE;
         end
      endcase
   end

   // Outputs per state.
   always_comb begin
      job_pop   = 1'b0;
      res_valid = 1'b0;
      res       = '0;
      case (state_ff)
         ES_IDLE: begin
            job_pop = job_valid;
         end
         ES_DECIDE: begin
            res_valid = 1'b1;
            res.kind  = d_kind;
            res.entry = d_entry;
            res.line  = d_line;
            res.tag   = d_tag;
            res.last  = d_last;
         end
         ES_WAKE: begin
            res_valid = 1'b1;
            if (wd_any) begin
               res.kind  = RK_RETRY_ISSUE_DOWN;
               res.entry = 4'(wd_idx);
               res.line  = 32'(down_line_ff[wd_idx]);
               res.tag   = down_tag_ff[wd_idx];
            end else begin
               res.kind  = RK_RETRY_ISSUE_UP;
               res.entry = 4'(wu_idx);
               res.line  = 32'(up_line_ff[wu_idx]);
               res.tag   = up_tag_ff[wu_idx];
            end
            res.last = !walk_more && !drain_pend_ff;
         end
         ES_DRAIN: begin
            res_valid = 1'b1;
            if (drain_up_ff) begin
               res.kind = RK_RETRY_INS_UP;
               res.line = 32'(pup_line_ff[drain_idx_ff[PIW-1:0]]);
               res.tag  = pup_tag_ff[drain_idx_ff[PIW-1:0]];
            end else begin
               res.kind = RK_RETRY_INS_DOWN;
               res.line = 32'(pdn_line_ff[drain_idx_ff[PIW-1:0]]);
               res.tag  = pdn_tag_ff[drain_idx_ff[PIW-1:0]];
            end
            res.last = drain_last;
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   assign commit = res_valid && res_ready;

   // Control state: phases, queue fills and the walk.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ES_IDLE;
         pdn_cnt_ff    <= '0;
         pup_cnt_ff    <= '0;
         wake_d_ff     <= '0;
         wake_u_ff     <= '0;
         drain_pend_ff <= 1'b0;
         drain_up_ff   <= 1'b0;
         drain_idx_ff  <= '0;
         for (int d = 0; d < DOWN_ENTRIES; d++) begin
            down_phase_ff[d] <= DP_FREE;
         end
         for (int u = 0; u < UP_ENTRIES; u++) begin
            up_phase_ff[u] <= UP_FREE;
         end
      end else begin
         state_ff <= state_in;
         if (commit && (state_ff == ES_DECIDE)) begin
            wake_d_ff     <= wd;
            wake_u_ff     <= wu;
            drain_pend_ff <= drain_go && (drain_cnt_now != '0);
            drain_up_ff   <= drain_sel_up;
            drain_idx_ff  <= '0;
            case (op_ff)
               OP_INSERT_DOWN: begin
                  if (df_found) begin
                     down_phase_ff[df_idx] <= DP_INACTIVE;
                  end else if (d_kind == RK_INSERT_DEFERRED) begin
                     pdn_cnt_ff <= pdn_cnt_ff + PCW'(1);
                  end
               end
               OP_INSERT_UP: begin
                  if (uf_found) begin
                     up_phase_ff[uf_idx] <= UP_SLEEP;
                  end else if (d_kind == RK_INSERT_DEFERRED) begin
                     pup_cnt_ff <= pup_cnt_ff + PCW'(1);
                  end
               end
               OP_ISSUE_DOWN: begin
                  if (d_kind == RK_ISSUE_GRANTED) begin
                     down_phase_ff[DIW'(id_ff)] <= DP_ACTIVE;
                  end
               end
               OP_ISSUE_UP: begin
                  if (d_kind == RK_ISSUE_GRANTED) begin
                     up_phase_ff[UIW'(id_ff)] <= UP_REQ;
                  end
               end
               OP_UP_TO_WAIT: begin
                  if (um_found) begin
                     up_phase_ff[um_idx] <= UP_WAIT;
                  end
               end
               OP_UP_TO_ACK: begin
                  if (um_found) begin
                     up_phase_ff[um_idx] <= UP_ACK;
                  end
               end
               OP_RETIRE_DOWN: begin
                  if (x_found) begin
                     down_phase_ff[x_idx] <= DP_FREE;
                  end
               end
               default: begin
                  if (um_found) begin
                     up_phase_ff[um_idx] <= UP_FREE;
                  end
               end
            endcase
         end
         if (commit && (state_ff == ES_WAKE)) begin
            wake_d_ff <= wd_rest;
            wake_u_ff <= wu_rest;
         end
         if (commit && (state_ff == ES_DRAIN)) begin
            drain_idx_ff <= drain_idx_ff + PCW'(1);
            if (drain_last) begin
               drain_pend_ff <= 1'b0;
               if (drain_up_ff) begin
                  pup_cnt_ff <= '0;
               end else begin
                  pdn_cnt_ff <= '0;
               end
            end
         end
      end
   end

   // Payload: match registers, entry contents, blockers and queued requests.
   always_ff @(posedge clock) begin
      if (job_pop) begin
         op_ff        <= job.op;
         id_ff        <= job.entry_id;
         tline_ff     <= m_line;
         ttag_ff      <= m_tag;
         id_ok_ff     <= m_ok;
         dline_hit_ff <= m_dline_hit;
         dset_act_ff  <= m_dset_act;
         uline_eq_ff  <= m_uline_eq;
         uset_eq_ff   <= m_uset_eq;
      end
      if (commit && (state_ff == ES_DECIDE)) begin
         case (op_ff)
            OP_INSERT_DOWN: begin
               if (df_found) begin
                  down_line_ff[df_idx]    <= tline_ff;
                  down_tag_ff[df_idx]     <= ttag_ff;
                  down_bk_kind_ff[df_idx] <= BK_NONE;
                  down_bk_idx_ff[df_idx]  <= '0;
               end else if (d_kind == RK_INSERT_DEFERRED) begin
                  pdn_line_ff[pdn_cnt_ff[PIW-1:0]] <= tline_ff;
                  pdn_tag_ff[pdn_cnt_ff[PIW-1:0]]  <= ttag_ff;
               end
            end
            OP_INSERT_UP: begin
               if (uf_found) begin
                  up_line_ff[uf_idx]    <= tline_ff;
                  up_tag_ff[uf_idx]     <= ttag_ff;
                  up_bk_kind_ff[uf_idx] <= BK_NONE;
                  up_bk_idx_ff[uf_idx]  <= '0;
               end else if (d_kind == RK_INSERT_DEFERRED) begin
                  pup_line_ff[pup_cnt_ff[PIW-1:0]] <= tline_ff;
                  pup_tag_ff[pup_cnt_ff[PIW-1:0]]  <= ttag_ff;
               end
            end
            OP_ISSUE_DOWN: begin
               if (id_ok_ff) begin
                  down_bk_kind_ff[DIW'(id_ff)] <= d_bk_kind;
                  down_bk_idx_ff[DIW'(id_ff)]  <= d_bk_idx;
               end
            end
            OP_ISSUE_UP: begin
               if (id_ok_ff) begin
                  up_bk_kind_ff[UIW'(id_ff)] <= d_bk_kind;
                  up_bk_idx_ff[UIW'(id_ff)]  <= d_bk_idx;
               end
            end
            OP_RETIRE_DOWN: begin
               if (x_found) begin
                  down_bk_kind_ff[x_idx] <= BK_NONE;
                  down_bk_idx_ff[x_idx]  <= '0;
               end
            end
            OP_RETIRE_UP: begin
               if (um_found) begin
                  up_bk_kind_ff[um_idx] <= BK_NONE;
                  up_bk_idx_ff[um_idx]  <= '0;
               end
            end
            default: begin
               // Wait and ack steps leave blockers alone.
            end
         endcase
      end
      // A retried waiter no longer waits on anything.
      if (commit && (state_ff == ES_WAKE)) begin
         if (wd_any) begin
            down_bk_kind_ff[wd_idx] <= BK_NONE;
            down_bk_idx_ff[wd_idx]  <= '0;
         end else begin
            up_bk_kind_ff[wu_idx] <= BK_NONE;
            up_bk_idx_ff[wu_idx]  <= '0;
         end
      end
   end

endmodule

[rtl/mcau_checker.sv]
// ----------------------------------------------------------------------------
// MSHR admission port checker
// Watches the top-level ports for result-word sanity after reset and during
// operation; attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
module mcau_checker
   import mcau_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       full,
   input logic       empty,
   input logic [3:0] rsp_result_kind,
   input logic [3:0] rsp_out_entry,
   input logic       rsp_last
);

   // Reset leaves both queues empty.
   assert property (@(posedge clock) reset |=> (empty && !full))
      else $error("queues not empty after reset");

   // Only defined result codes reach the port.
   assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_result_kind <= RK_NO_MATCH))
      else $error("undefined result code");

   // Deferred, dropped and queued-insert retries carry no entry number.
   assert property (@(posedge clock) disable iff (reset)
      (!empty && ((rsp_result_kind == RK_INSERT_DEFERRED) ||
                  (rsp_result_kind == RK_INSERT_DROPPED) ||
                  (rsp_result_kind == RK_RETRY_INS_DOWN) ||
                  (rsp_result_kind == RK_RETRY_INS_UP))) |-> (rsp_out_entry == 4'd0))
      else $error("insert word carries an entry number");

   // Insert and issue answers are always the only word of their request.
   assert property (@(posedge clock) disable iff (reset)
      (!empty && ((rsp_result_kind == RK_INSERT_GRANTED) ||
                  (rsp_result_kind == RK_INSERT_DEFERRED) ||
                  (rsp_result_kind == RK_INSERT_DROPPED) ||
                  (rsp_result_kind == RK_ISSUE_GRANTED) ||
                  (rsp_result_kind == RK_ISSUE_BLOCKED))) |-> rsp_last)
      else $error("single-word answer without last");

endmodule

bind mshr_conflict_admission_unit mcau_checker u_checker (.*);

[dv/mshr_conflict_admission_unit_tb.sv]
// ----------------------------------------------------------------------------
// MSHR conflict admission unit testbench
// Drives request words through the push/full queue and checks every result
// word against a behavioral copy of the miss-status table. The copy tracks
// entry phases, blockers, pending-insert queues and both CSRs. Directed
// tests come first, then pending-queue overflow under back-pressure, then
// random request streams under several CSR settings.
// ----------------------------------------------------------------------------
module mshr_conflict_admission_unit_tb;
   import mcau_pkg::*;

   localparam int N_DOWN     = 16;
   localparam int N_UP       = 8;
   localparam int PEND_DEPTH = 16;
   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_LEN   = 300;

   logic                     clock;
   logic                     reset;
   logic                     push;
   logic                     full;
   logic [2:0]               req_action;
   logic [31:0]              req_line_addr;
   logic [3:0]               req_entry_id;
   logic [7:0]               req_tag;
   logic                     empty;
   logic                     pop;
   logic [3:0]               rsp_result_kind;
   logic [3:0]               rsp_out_entry;
   logic [31:0]              rsp_out_line;
   logic [7:0]               rsp_out_tag;
   logic                     rsp_last;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [31:0]              pwdata;
   logic [31:0]              prdata;
   logic                     pready;

   mshr_conflict_admission_unit dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_action(req_action), .req_line_addr(req_line_addr),
      .req_entry_id(req_entry_id), .req_tag(req_tag),
      .empty(empty), .pop(pop),
      .rsp_result_kind(rsp_result_kind), .rsp_out_entry(rsp_out_entry),
      .rsp_out_line(rsp_out_line), .rsp_out_tag(rsp_out_tag), .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Shadow of the table and CSRs.
   logic [31:0] sh_mask;
   logic [4:0]  sh_ways;
   logic [1:0]  dn_phase [N_DOWN];
   logic [31:0] dn_line  [N_DOWN];
   logic [7:0]  dn_tag   [N_DOWN];
   logic [5:0]  dn_blk   [N_DOWN];
   logic [2:0]  up_phase [N_UP];
   logic [31:0] up_line  [N_UP];
   logic [7:0]  up_tag   [N_UP];
   logic [5:0]  up_blk   [N_UP];
   logic [39:0] pend_dn [$];
   logic [39:0] pend_up [$];

   // Result words still owed by the block, oldest first.
   rsp_type     owed_words [$];

   int          mismatches;
   int          tx_max;
   int          rx_max;
   int          rx_wait;
   int          hold_cycles;
   int          hold_req;
   int          hold_seen;
   int          quiet_cycles;
   logic [31:0] line_pool [8];

   // Clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   function automatic int find_active_down(logic [31:0] line);
      for (int e = 0; e < N_DOWN; e++)
         if (dn_phase[e] == DP_ACTIVE && dn_line[e] == line) return e;
      return -1;
   endfunction

   function automatic int find_issued_up(logic [31:0] set_idx);
      for (int u = 0; u < N_UP; u++)
         if (up_phase[u] >= UP_REQ && up_phase[u] <= UP_ACK &&
             (up_line[u] & sh_mask) == set_idx) return u;
      return -1;
   endfunction

   task automatic owe(kind_type k, logic [3:0] ent, logic [31:0] line, logic [7:0] tag);
      rsp_type w;
      w.kind  = k;
      w.entry = ent;
      w.line  = line;
      w.tag   = tag;
      w.last  = 1'b0;
      owed_words.push_back(w);
   endtask

   // Retries every waiter on the released blocker, in entry order.
   task automatic wake_waiters(logic [5:0] code, bit ups, bit count_set, logic [31:0] set_idx);
      for (int i = 0; i < N_DOWN; i++)
         if (dn_phase[i] == DP_INACTIVE && dn_blk[i] == code) begin
            dn_blk[i] = '0;
            owe(RK_RETRY_ISSUE_DOWN, 4'(i), dn_line[i], dn_tag[i]);
         end
      if (ups)
         for (int i = 0; i < N_UP; i++)
            if (up_phase[i] == UP_SLEEP && (up_blk[i] == code ||
                (count_set && up_blk[i] == {BK_COUNT, 4'd0} &&
                 (up_line[i] & sh_mask) == set_idx))) begin
               up_blk[i] = '0;
               owe(RK_RETRY_ISSUE_UP, 4'(i), up_line[i], up_tag[i]);
            end
   endtask

   task automatic table_reset();
      sh_mask = SET_MASK_RESET;
      sh_ways = WAYS_RESET;
      for (int i = 0; i < N_DOWN; i++) begin
         dn_phase[i] = DP_FREE; dn_line[i] = '0; dn_tag[i] = '0; dn_blk[i] = '0;
      end
      for (int i = 0; i < N_UP; i++) begin
         up_phase[i] = UP_FREE; up_line[i] = '0; up_tag[i] = '0; up_blk[i] = '0;
      end
      pend_dn.delete();
      pend_up.delete();
   endtask

   // Works out the result words of one accepted request word.
   task automatic table_apply(op_type op, logic [31:0] line, logic [3:0] id, logic [7:0] tag);
      int          first;
      int          x;
      int          u;
      int          hits;
      logic [31:0] s;
      first = owed_words.size();
      case (op)
         OP_INSERT_DOWN: begin
            x = -1;
            for (int e = 0; e < N_DOWN; e++)
               if (x < 0 && dn_phase[e] == DP_FREE) x = e;
            if (x >= 0) begin
               dn_phase[x] = DP_INACTIVE; dn_line[x] = line; dn_tag[x] = tag; dn_blk[x] = '0;
               owe(RK_INSERT_GRANTED, 4'(x), line, tag);
            end else if (pend_dn.size() < PEND_DEPTH) begin
               pend_dn.push_back({line, tag});
               owe(RK_INSERT_DEFERRED, 4'd0, line, tag);
            end else owe(RK_INSERT_DROPPED, 4'd0, line, tag);
         end
         OP_INSERT_UP: begin
            x = -1;
            for (int e = 0; e < N_UP; e++)
               if (x < 0 && up_phase[e] == UP_FREE) x = e;
            if (x >= 0) begin
               up_phase[x] = UP_SLEEP; up_line[x] = line; up_tag[x] = tag; up_blk[x] = '0;
               owe(RK_INSERT_GRANTED, 4'(x), line, tag);
            end else if (pend_up.size() < PEND_DEPTH) begin
               pend_up.push_back({line, tag});
               owe(RK_INSERT_DEFERRED, 4'd0, line, tag);
            end else owe(RK_INSERT_DROPPED, 4'd0, line, tag);
         end
         OP_ISSUE_DOWN: begin
            if (dn_phase[id] != DP_INACTIVE) owe(RK_NO_MATCH, id, '0, '0);
            else begin
               x = find_active_down(dn_line[id]);
               if (x >= 0) dn_blk[id] = {BK_DOWN, 4'(x)};
               else begin
                  u = find_issued_up(dn_line[id] & sh_mask);
                  if (u >= 0 && (up_phase[u] == UP_REQ ||
                      (up_phase[u] == UP_ACK && up_line[u] == dn_line[id])))
                     dn_blk[id] = {BK_UP, 4'(u)};
                  else begin
                     dn_phase[id] = DP_ACTIVE; dn_blk[id] = '0;
                  end
               end
               if (dn_phase[id] == DP_ACTIVE) owe(RK_ISSUE_GRANTED, id, dn_line[id], dn_tag[id]);
               else owe(RK_ISSUE_BLOCKED, id, dn_line[id], dn_tag[id]);
            end
         end
         OP_ISSUE_UP: begin
            if (id >= N_UP || up_phase[id] != UP_SLEEP) owe(RK_NO_MATCH, id, '0, '0);
            else begin
               s = up_line[id] & sh_mask;
               u = find_issued_up(s);
               x = find_active_down(up_line[id]);
               hits = 0;
               for (int d = 0; d < N_DOWN; d++)
                  if (dn_phase[d] == DP_ACTIVE && (dn_line[d] & sh_mask) == s) hits++;
               if (u >= 0) up_blk[id] = {BK_UP, 4'(u)};
               else if (x >= 0) up_blk[id] = {BK_DOWN, 4'(x)};
               else if (hits >= sh_ways) up_blk[id] = {BK_COUNT, 4'd0};
               else begin
                  up_phase[id] = UP_REQ; up_blk[id] = '0;
               end
               if (up_phase[id] == UP_REQ) owe(RK_ISSUE_GRANTED, id, up_line[id], up_tag[id]);
               else owe(RK_ISSUE_BLOCKED, id, up_line[id], up_tag[id]);
            end
         end
         OP_RETIRE_DOWN: begin
            x = find_active_down(line);
            if (x < 0) owe(RK_NO_MATCH, 4'd0, line, '0);
            else begin
               owe(RK_UPDATED, 4'(x), dn_line[x], dn_tag[x]);
               dn_phase[x] = DP_FREE; dn_blk[x] = '0;
               wake_waiters({BK_DOWN, 4'(x)}, 1'b1, 1'b1, line & sh_mask);
               foreach (pend_dn[i]) owe(RK_RETRY_INS_DOWN, 4'd0, pend_dn[i][39:8], pend_dn[i][7:0]);
               pend_dn.delete();
            end
         end
         default: begin
            // Upgrade steps: up-to-wait, up-to-ack and retire of an upgrade.
            x = -1;
            for (int i = 0; i < N_UP; i++)
               if (x < 0 && up_line[i] == line &&
                   ((op == OP_UP_TO_WAIT && up_phase[i] == UP_REQ) ||
                    (op == OP_UP_TO_ACK && (up_phase[i] == UP_REQ || up_phase[i] == UP_WAIT)) ||
                    (op == OP_RETIRE_UP && up_phase[i] == UP_ACK)))
                  x = i;
            if (x < 0) owe(RK_NO_MATCH, 4'd0, line, '0);
            else begin
               owe(RK_UPDATED, 4'(x), up_line[x], up_tag[x]);
               if (op == OP_UP_TO_WAIT) begin
                  up_phase[x] = UP_WAIT;
                  wake_waiters({BK_UP, 4'(x)}, 1'b0, 1'b0, '0);
               end else if (op == OP_UP_TO_ACK) up_phase[x] = UP_ACK;
               else begin
                  up_phase[x] = UP_FREE; up_blk[x] = '0;
                  wake_waiters({BK_UP, 4'(x)}, 1'b1, 1'b0, '0);
                  foreach (pend_up[i]) owe(RK_RETRY_INS_UP, 4'd0, pend_up[i][39:8], pend_up[i][7:0]);
                  pend_up.delete();
               end
            end
         end
      endcase
      if (owed_words.size() > first) owed_words[owed_words.size() - 1].last = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------------

   // Offers one request word and waits until the block takes it.
   task automatic send_word(op_type op, logic [31:0] line, logic [3:0] id, logic [7:0] tag);
      int gap;
      gap = $urandom_range(0, tx_max);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push          <= 1'b1;
      req_action    <= op;
      req_line_addr <= line;
      req_entry_id  <= id;
      req_tag       <= tag;
      do @(posedge clock); while (full);
      table_apply(op, line, id, tag);
   endtask

   // Holds push low, lets every owed word come back, then idles.
   task automatic drain_all();
      push <= 1'b0;
      while (owed_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the write lands at the access edge.
   task automatic csr_write(csr_reg_type r, logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_BITS'({r, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (r == CSR_REG_SET_MASK) sh_mask = value;
      else sh_ways = value[4:0];
   endtask

   task automatic new_setting(logic [31:0] mask, logic [4:0] ways);
      drain_all();
      csr_write(CSR_REG_SET_MASK, mask);
      csr_write(CSR_REG_WAYS, {27'd0, ways});
      // Lines that share a few sets so the conflict rules fire often.
      foreach (line_pool[i]) line_pool[i] = ($urandom() << 10) | $urandom_range(0, 3);
   endtask

   function automatic int pick_down(logic [1:0] ph);
      int c [$];
      for (int i = 0; i < N_DOWN; i++) if (dn_phase[i] == ph) c.push_back(i);
      if (c.size() == 0) return -1;
      return c[$urandom_range(0, c.size() - 1)];
   endfunction

   function automatic int pick_up(logic [2:0] ph_lo, logic [2:0] ph_hi);
      int c [$];
      for (int i = 0; i < N_UP; i++)
         if (up_phase[i] >= ph_lo && up_phase[i] <= ph_hi) c.push_back(i);
      if (c.size() == 0) return -1;
      return c[$urandom_range(0, c.size() - 1)];
   endfunction

   // One random request word, mostly steering entries along their life.
   task automatic random_word();
      int          r;
      int          k;
      logic [31:0] line;
      logic [3:0]  id;
      logic [7:0]  tag;
      r    = $urandom_range(0, 99);
      line = ($urandom_range(0, 4) == 0) ? $urandom() : line_pool[$urandom_range(0, 7)];
      id   = $urandom_range(0, 15);
      tag  = $urandom_range(0, 255);
      if (r < 8) send_word(op_type'($urandom_range(0, 7)), $urandom(), id, tag);
      else if (r < 24) send_word(OP_INSERT_DOWN, line, id, tag);
      else if (r < 36) send_word(OP_INSERT_UP, line, id, tag);
      else if (r < 52) begin
         k = pick_down(DP_INACTIVE);
         send_word(OP_ISSUE_DOWN, line, (k >= 0) ? 4'(k) : id, tag);
      end else if (r < 64) begin
         k = pick_up(UP_SLEEP, UP_SLEEP);
         send_word(OP_ISSUE_UP, line, (k >= 0) ? 4'(k) : id, tag);
      end else if (r < 73) begin
         k = pick_up(UP_REQ, UP_REQ);
         send_word(OP_UP_TO_WAIT, (k >= 0) ? up_line[k] : line, id, tag);
      end else if (r < 82) begin
         k = pick_up(UP_REQ, UP_WAIT);
         send_word(OP_UP_TO_ACK, (k >= 0) ? up_line[k] : line, id, tag);
      end else if (r < 92) begin
         k = pick_down(DP_ACTIVE);
         send_word(OP_RETIRE_DOWN, (k >= 0) ? dn_line[k] : line, id, tag);
      end else begin
         k = pick_up(UP_ACK, UP_ACK);
         send_word(OP_RETIRE_UP, (k >= 0) ? up_line[k] : line, id, tag);
      end
   endtask

   // ------------------------------------------------------------------------
   // Result side: random pop stalls and checking of each popped word
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            got.kind  = kind_type'(rsp_result_kind);
            got.entry = rsp_out_entry;
            got.line  = rsp_out_line;
            got.tag   = rsp_out_tag;
            got.last  = rsp_last;
            if (owed_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result word: kind %0d entry %0d line %h tag %h last %b",
                           got.kind, got.entry, got.line, got.tag, got.last);
            end else begin
               want = owed_words.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected kind %0d entry %0d line %h tag %h last %b, %s",
                              want.kind, want.entry, want.line, want.tag, want.last,
                              $sformatf("got kind %0d entry %0d line %h tag %h last %b",
                                        got.kind, got.entry, got.line, got.tag, got.last));
               end
            end
            rx_wait = $urandom_range(0, rx_max);
         end
         if (hold_cycles > 0 || rx_wait > 0) begin
            pop <= 1'b0;
            if (rx_wait > 0 && hold_cycles == 0) rx_wait--;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // Long receiver hold-off, started on request and counted down on its own.
   always @(posedge clock) begin
      if (reset) begin
         hold_cycles <= 0;
         hold_seen   <= 0;
      end else if (hold_seen != hold_req) begin
         hold_cycles <= HOLD_LEN;
         hold_seen   <= hold_req;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset CSRs: grant, line and set conflicts, wake on retire, bad entries.
   task automatic test_directed_rules();
      logic [31:0] a;
      logic [31:0] b;
      a = 32'h0000_0401;
      b = 32'h0000_0801;     // same set as a under the reset mask
      tx_max = 3; rx_max = 3;
      send_word(OP_INSERT_DOWN, a, 4'd0, 8'h00);
      send_word(OP_INSERT_DOWN, a, 4'd0, 8'hFF);
      send_word(OP_ISSUE_DOWN, 32'd0, 4'd0, 8'd0);
      send_word(OP_ISSUE_DOWN, 32'd0, 4'd1, 8'd0);    // blocked on the active line
      send_word(OP_INSERT_UP, b, 4'd0, 8'h5A);
      send_word(OP_ISSUE_UP, 32'd0, 4'd0, 8'd0);
      send_word(OP_INSERT_DOWN, b, 4'd0, 8'hA5);
      send_word(OP_ISSUE_DOWN, 32'd0, 4'd2, 8'd0);    // upgrade in req blocks the set
      send_word(OP_UP_TO_WAIT, b, 4'd0, 8'd0);        // retries the downgrade
      send_word(OP_UP_TO_ACK, b, 4'd0, 8'd0);
      send_word(OP_ISSUE_DOWN, 32'd0, 4'd2, 8'd0);    // ack on the same line blocks
      send_word(OP_RETIRE_DOWN, a, 4'd0, 8'd0);       // retries the first waiter
      send_word(OP_RETIRE_UP, b, 4'd0, 8'd0);
      send_word(OP_ISSUE_DOWN, 32'd0, 4'd15, 8'd0);   // free entry
      send_word(OP_ISSUE_UP, 32'd0, 4'd12, 8'd0);     // out of range
      send_word(OP_RETIRE_DOWN, 32'hFFFF_FFFF, 4'd0, 8'd0);
      send_word(OP_RETIRE_UP, 32'hFFFF_FFFF, 4'd0, 8'd0);
      send_word(OP_UP_TO_WAIT, 32'h1234_5678, 4'd0, 8'd0);
      send_word(OP_UP_TO_ACK, 32'h1234_5678, 4'd0, 8'd0);
      send_word(OP_ISSUE_DOWN, 32'd0, 4'd0, 8'd0);    // entry freed by the retire
   endtask

   // Ways of zero blocks every upgrade; a downgrade retire retries it.
   task automatic test_ways_extremes();
      new_setting(32'd0, 5'd0);
      send_word(OP_INSERT_UP, 32'hDEAD_BEEF, 4'd0, 8'h11);
      send_word(OP_ISSUE_UP, 32'd0, 4'(pick_up(UP_SLEEP, UP_SLEEP)), 8'd0);
      send_word(OP_INSERT_DOWN, 32'h0BAD_F00D, 4'd0, 8'h22);
      send_word(OP_ISSUE_DOWN, 32'd0, 4'(pick_down(DP_INACTIVE)), 8'd0);
      send_word(OP_RETIRE_DOWN, 32'h0BAD_F00D, 4'd0, 8'd0);
      new_setting(32'hFFFF_FFFF, 5'd31);
      send_word(OP_INSERT_UP, 32'h0000_0000, 4'd0, 8'h33);
      send_word(OP_ISSUE_UP, 32'd0, 4'(pick_up(UP_SLEEP, UP_SLEEP)), 8'd0);
   endtask

   // Both pending queues overflow while the receiver holds off.
   task automatic test_pending_overflow();
      new_setting(32'd1023, 5'd8);
      tx_max = 0;
      hold_req++;
      repeat (N_UP + PEND_DEPTH + 2)
         send_word(OP_INSERT_UP, $urandom(), 4'd0, $urandom_range(0, 255));
      repeat (N_DOWN + PEND_DEPTH + 2)
         send_word(OP_INSERT_DOWN, $urandom(), 4'd0, $urandom_range(0, 255));
   endtask

   // Random streams under several CSR settings and idle patterns.
   task automatic test_random_streams();
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: new_setting(32'd1023, 5'd8);
            1: new_setting(32'd0, 5'd1);
            2: new_setting(32'hFFFF_FFFF, 5'd16);
            3: new_setting(32'd3, 5'd2);
            4: new_setting($urandom(), 5'($urandom_range(1, 16)));
            default: new_setting(32'd1, 5'd31);
         endcase
         tx_max = (ph % 2 == 0) ? 9 : 0;
         rx_max = (ph % 3 == 1) ? 0 : 9;
         repeat (40) random_word();
      end
   endtask

   initial begin
      reset = 1'b1;
      push = 1'b0; req_action = OP_INSERT_DOWN; req_line_addr = '0;
      req_entry_id = '0; req_tag = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      mismatches = 0; rx_wait = 0; hold_req = 0; quiet_cycles = 0;
      tx_max = 9; rx_max = 9;
      table_reset();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_rules();
      test_ways_extremes();
      test_pending_overflow();
      test_random_streams();
      drain_all();

      if (mismatches == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
